// ===== hw/rtl/cst_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and character helpers for the C subset tokeniser.
// Used by cst_lexer, cst_result_fifo, c_subset_tokenizer and the testbench.
package cst_pkg;

  // default widths
  localparam int unsigned POSITION_BITS_DEF = 32;
  localparam int unsigned LENGTH_BITS_DEF   = 16;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned KIND_W = 4;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned WIN_W  = 48;

  // token kinds
  localparam logic [KIND_W-1:0] KIND_IDENT  = 4'd0;
  localparam logic [KIND_W-1:0] KIND_INT    = 4'd1;
  localparam logic [KIND_W-1:0] KIND_VOID   = 4'd2;
  localparam logic [KIND_W-1:0] KIND_RETURN = 4'd3;
  localparam logic [KIND_W-1:0] KIND_CONST  = 4'd4;
  localparam logic [KIND_W-1:0] KIND_LPAREN = 4'd5;
  localparam logic [KIND_W-1:0] KIND_RPAREN = 4'd6;
  localparam logic [KIND_W-1:0] KIND_LBRACE = 4'd7;
  localparam logic [KIND_W-1:0] KIND_RBRACE = 4'd8;
  localparam logic [KIND_W-1:0] KIND_SEMI   = 4'd9;
  localparam logic [KIND_W-1:0] KIND_END    = 4'd10;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK          = 2'd0;
  localparam logic [STAT_W-1:0] ST_LETTER_AFTER_CONST = 2'd1;
  localparam logic [STAT_W-1:0] ST_UNEXPECTED  = 2'd2;

  // characters
  localparam logic [BYTE_W-1:0] CH_NUL    = 8'h00;
  localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
  localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [BYTE_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [BYTE_W-1:0] CH_LBRACE = 8'h7B;
  localparam logic [BYTE_W-1:0] CH_RBRACE = 8'h7D;
  localparam logic [BYTE_W-1:0] CH_SEMI   = 8'h3B;
  localparam logic [BYTE_W-1:0] CH_UNDER  = 8'h5F;

  // keyword spellings, last byte lowest
  localparam logic [23:0] KW_INT    = 24'h696E74;
  localparam logic [31:0] KW_VOID   = 32'h766F6964;
  localparam logic [47:0] KW_RETURN = 48'h72657475726E;

  // result queue
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = FIFO_PTR_W + 1;

  // scanner state, one-hot
  typedef enum logic [3:0] {
    MODE_IDLE  = 4'b0001,
    MODE_IDENT = 4'b0010,
    MODE_CONST = 4'b0100,
    MODE_DROP  = 4'b1000
  } scan_mode_e;

  // low part of every queued result
  typedef struct packed {
    logic              last;
    logic [STAT_W-1:0] status;
    logic [KIND_W-1:0] kind;
  } res_meta_t;

  localparam int unsigned META_W = $bits(res_meta_t);

  function automatic logic is_letter(input logic [BYTE_W-1:0] b);
    return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) || b == CH_UNDER;
  endfunction

  function automatic logic is_digit(input logic [BYTE_W-1:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic logic is_space(input logic [BYTE_W-1:0] b);
    return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
  endfunction

  // punctuator kind, KIND_IDENT when the byte is none
  function automatic logic [KIND_W-1:0] punct_kind(input logic [BYTE_W-1:0] b);
    logic [KIND_W-1:0] k;
    k = KIND_IDENT;
    if (b == CH_LPAREN) k = KIND_LPAREN;
    if (b == CH_RPAREN) k = KIND_RPAREN;
    if (b == CH_LBRACE) k = KIND_LBRACE;
    if (b == CH_RBRACE) k = KIND_RBRACE;
    if (b == CH_SEMI)   k = KIND_SEMI;
    return k;
  endfunction

endpackage

// ===== hw/rtl/cst_lexer.sv =====
`timescale 1ns / 1ps
// Scanner core: input byte register, scan state and the per-byte token step.
// Depends on cst_pkg.
module cst_lexer #(
  parameter int unsigned POSITION_BITS = cst_pkg::POSITION_BITS_DEF,
  parameter int unsigned LENGTH_BITS   = cst_pkg::LENGTH_BITS_DEF,
  parameter int unsigned RES_W = cst_pkg::META_W + POSITION_BITS + LENGTH_BITS
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [cst_pkg::BYTE_W-1:0] in_byte_i,
  input  logic                      room_i,     // queue can take two results
  output logic                      push0_o,
  output logic                      push1_o,
  output logic [RES_W-1:0]          res0_o,
  output logic [RES_W-1:0]          res1_o
);
  import cst_pkg::*;

  logic                     valid_q, valid_d;
  logic [BYTE_W-1:0]        byte_q;
  scan_mode_e               mode_q, mode_d;
  logic [POSITION_BITS-1:0] pos_q, pos_d, start_q, start_d, pos_inc;
  logic [LENGTH_BITS-1:0]   len_q, len_d, len_grow;
  logic [WIN_W-1:0]         win_q, win_d;
  logic                     fire;

  logic                     is_let, is_dig, cont;
  logic [KIND_W-1:0]        pkind, id_kind;
  logic                     flush_v, own_v;
  logic [KIND_W-1:0]        flush_kind, own_kind;
  logic [STAT_W-1:0]        own_status;
  logic [LENGTH_BITS-1:0]   own_len;
  res_meta_t                flush_meta, own_meta;

  assign fire       = valid_q && room_i;
  assign in_ready_o = !valid_q || room_i;

  always_comb begin
    valid_d = valid_q;
    if (in_valid_i && in_ready_o) begin
      valid_d = 1'b1;
    end else if (fire) begin
      valid_d = 1'b0;
    end
  end

  assign is_let   = is_letter(byte_q);
  assign is_dig   = is_digit(byte_q);
  assign pkind    = punct_kind(byte_q);
  assign pos_inc  = pos_q + POSITION_BITS'(1);
  assign len_grow = (len_q == '1) ? len_q : len_q + LENGTH_BITS'(1);

  always_comb begin
    id_kind = KIND_IDENT;
    if (len_q == LENGTH_BITS'(3) && win_q[23:0] == KW_INT) begin
      id_kind = KIND_INT;
    end else if (len_q == LENGTH_BITS'(4) && win_q[31:0] == KW_VOID) begin
      id_kind = KIND_VOID;
    end else if (len_q == LENGTH_BITS'(6) && win_q == KW_RETURN) begin
      id_kind = KIND_RETURN;
    end
  end

  // one byte: optional finished token, then the byte's own result
  always_comb begin
    mode_d     = mode_q;
    pos_d      = pos_q;
    start_d    = start_q;
    len_d      = len_q;
    win_d      = win_q;
    flush_v    = 1'b0;
    flush_kind = KIND_IDENT;
    own_v      = 1'b0;
    own_kind   = KIND_IDENT;
    own_status = ST_OK;
    own_len    = '0;
    cont       = 1'b1;
    unique case (mode_q)
      MODE_DROP: begin
        cont = 1'b0;
        if (byte_q == CH_NUL) begin
          mode_d = MODE_IDLE;
          pos_d  = '0;
        end else begin
          pos_d = pos_inc;
        end
      end
      MODE_IDENT: begin
        if (is_let || is_dig) begin
          cont  = 1'b0;
          len_d = len_grow;
          win_d = {win_q[WIN_W-BYTE_W-1:0], byte_q};
          pos_d = pos_inc;
        end else begin
          flush_v    = 1'b1;
          flush_kind = id_kind;
          mode_d     = MODE_IDLE;
        end
      end
      MODE_CONST: begin
        if (is_dig) begin
          cont  = 1'b0;
          len_d = len_grow;
          pos_d = pos_inc;
        end else if (is_let) begin
          // constant dropped, only the error goes out
          cont       = 1'b0;
          own_v      = 1'b1;
          own_status = ST_LETTER_AFTER_CONST;
          mode_d     = MODE_DROP;
          pos_d      = pos_inc;
        end else begin
          flush_v    = 1'b1;
          flush_kind = KIND_CONST;
          mode_d     = MODE_IDLE;
        end
      end
      MODE_IDLE: begin
        cont = 1'b1;
      end
      default: begin
        mode_d = MODE_IDLE;
      end
    endcase

    if (cont) begin
      pos_d = pos_inc;
      priority if (byte_q == CH_NUL) begin
        own_v    = 1'b1;
        own_kind = KIND_END;
        pos_d    = '0;
      end else if (is_space(byte_q)) begin
        pos_d = pos_inc;
      end else if (is_let) begin
        mode_d  = MODE_IDENT;
        start_d = pos_q;
        len_d   = LENGTH_BITS'(1);
        win_d   = WIN_W'(byte_q);
      end else if (is_dig) begin
        mode_d  = MODE_CONST;
        start_d = pos_q;
        len_d   = LENGTH_BITS'(1);
      end else if (pkind != KIND_IDENT) begin
        own_v    = 1'b1;
        own_kind = pkind;
        own_len  = LENGTH_BITS'(1);
      end else begin
        own_v      = 1'b1;
        own_status = ST_UNEXPECTED;
        mode_d     = MODE_DROP;
      end
    end
  end

  assign flush_meta = '{last: !own_v, status: ST_OK, kind: flush_kind};
  assign own_meta   = '{last: 1'b1, status: own_status, kind: own_kind};

  always_comb begin
    if (flush_v) begin
      res0_o = {len_q, start_q, flush_meta};
    end else begin
      res0_o = {own_len, pos_q, own_meta};
    end
  end
  assign res1_o  = {own_len, pos_q, own_meta};
  assign push0_o = fire && (flush_v || own_v);
  assign push1_o = fire && flush_v && own_v;

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= in_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      mode_q  <= MODE_IDLE;
      pos_q   <= '0;
      start_q <= '0;
      len_q   <= '0;
      win_q   <= '0;
    end else begin
      valid_q <= valid_d;
      if (fire) begin
        mode_q  <= mode_d;
        pos_q   <= pos_d;
        start_q <= start_d;
        len_q   <= len_d;
        win_q   <= win_d;
      end
    end
  end

  a_err_drops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && own_v && own_status != ST_OK |=> mode_q == MODE_DROP)
    else $error("error result without drop mode");
  a_nul_rewinds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && byte_q == CH_NUL |=> pos_q == '0 && mode_q == MODE_IDLE)
    else $error("zero byte did not rewind position");
  a_ident_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_IDENT || mode_q == MODE_CONST) |-> len_q != '0)
    else $error("open token with zero length");

endmodule

// ===== hw/rtl/cst_result_fifo.sv =====
`timescale 1ns / 1ps
// Small result queue taking up to two results per cycle, giving one.
// Depends on cst_pkg.
module cst_result_fifo #(
  parameter int unsigned W = cst_pkg::META_W + cst_pkg::POSITION_BITS_DEF
                           + cst_pkg::LENGTH_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push0_i,
  input  logic         push1_i,
  input  logic [W-1:0] data0_i,
  input  logic [W-1:0] data1_i,
  output logic         room_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic [W-1:0] out_data_o
);
  import cst_pkg::*;

  logic [W-1:0]          mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_q, wr_d, wr_nxt, rd_q, rd_d;
  logic [FIFO_CNT_W-1:0] cnt_q, cnt_d;
  logic                  pop;

  assign wr_nxt      = wr_q + FIFO_PTR_W'(1);
  assign out_valid_o = cnt_q != '0;
  assign out_data_o  = mem_q[rd_q];
  assign pop         = out_valid_o && out_ready_i;
  assign room_o      = cnt_q <= FIFO_CNT_W'(FIFO_DEPTH - 2);

  always_comb begin
    wr_d  = wr_q + FIFO_PTR_W'(push0_i) + FIFO_PTR_W'(push1_i);
    rd_d  = rd_q + FIFO_PTR_W'(pop);
    cnt_d = cnt_q + FIFO_CNT_W'(push0_i) + FIFO_CNT_W'(push1_i) - FIFO_CNT_W'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push0_i) begin
      mem_q[wr_q] <= data0_i;
    end
    if (push1_i) begin
      mem_q[wr_nxt] <= data1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push0_i |-> cnt_q <= FIFO_CNT_W'(FIFO_DEPTH - 2))
    else $error("push into full queue");
  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push1_i |-> push0_i)
    else $error("second result without first");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("queue count out of range");

endmodule

// ===== hw/rtl/c_subset_tokenizer.sv =====
`timescale 1ns / 1ps
// C subset tokeniser, top level. Byte stream in, token stream out.
// Depends on cst_pkg, cst_lexer and cst_result_fifo.
//
// Source bytes arrive one per request on the slave stream; a zero byte ends the
// source and rewinds the byte offset to zero. Whitespace is skipped; identifiers
// (with int, void and return promoted to keywords), decimal constants and the
// punctuators ( ) { } ; come out as requests of kind, status, start offset and
// length. Identifiers and constants are reported when the byte that ends them
// arrives, so one byte can give two results; tlast marks the final result of
// each byte. A letter straight after a constant, or any other unknown byte,
// gives an error result and everything up to the next zero byte is discarded
// silently. Lengths saturate at 2^LENGTH_BITS-1; offsets wrap.
// Timing: one byte accepted per cycle, sustained, as long as the output keeps
// up; a result passes the input register and then a four-entry result queue
// that also serves as the output register before it is valid on the output.
// A byte producing two results gives them out one after the other, and the
// queue absorbs short bursts of these before tready drops.
module c_subset_tokenizer #(
  parameter int unsigned POSITION_BITS = cst_pkg::POSITION_BITS_DEF,
  parameter int unsigned LENGTH_BITS   = cst_pkg::LENGTH_BITS_DEF,
  parameter int unsigned DATA_W = ((POSITION_BITS + LENGTH_BITS + 7) / 8) * 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // byte stream in
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [7:0]        s_axis_tdata_i,   // [7:0] source_byte
  // token stream out
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [DATA_W-1:0] m_axis_tdata_o,   // start_position, token_length, zero pad
  output logic [5:0]        m_axis_tuser_o,   // [3:0] token_kind, [5:4] status
  output logic              m_axis_tlast_o    // last result of this byte
);
  import cst_pkg::*;

  localparam int unsigned RES_W = META_W + POSITION_BITS + LENGTH_BITS;

  logic             room, push0, push1;
  logic [RES_W-1:0] res0, res1, head;
  res_meta_t        head_meta;

  cst_lexer #(
    .POSITION_BITS(POSITION_BITS),
    .LENGTH_BITS  (LENGTH_BITS),
    .RES_W        (RES_W)
  ) u_lexer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid_i),
    .in_ready_o(s_axis_tready_o),
    .in_byte_i (s_axis_tdata_i),
    .room_i    (room),
    .push0_o   (push0),
    .push1_o   (push1),
    .res0_o    (res0),
    .res1_o    (res1)
  );

  cst_result_fifo #(
    .W(RES_W)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push0_i    (push0),
    .push1_i    (push1),
    .data0_i    (res0),
    .data1_i    (res1),
    .room_o     (room),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .out_data_o (head)
  );

  // queued word is {length, start, meta}
  assign head_meta      = res_meta_t'(head[META_W-1:0]);
  assign m_axis_tuser_o = {head_meta.status, head_meta.kind};
  assign m_axis_tlast_o = head_meta.last;
  assign m_axis_tdata_o = DATA_W'(head[RES_W-1:META_W]);

endmodule

// ===== tb/cst_token_checker.sv =====
`timescale 1ns / 1ps
// Token checker for the C subset tokeniser: predicts the token stream from the
// accepted source bytes and compares every accepted result. Depends on cst_pkg.
module cst_token_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [7:0]  s_tdata_i,   // [7:0] source_byte
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [47:0] m_tdata_i,   // [31:0] start_position, [47:32] token_length
  input  logic [5:0]  m_tuser_i,   // [3:0] token_kind, [5:4] status
  input  logic        m_tlast_i,   // last result of its byte
  output int          failures_o,
  output int          outstanding_o,
  output int          checked_o
);
  import cst_pkg::*;

  localparam logic [15:0] LEN_SAT = 16'hFFFF;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [STAT_W-1:0] status;
    logic [31:0]       start;
    logic [15:0]       length;
    logic              last;
  } token_t;

  typedef enum logic [2:0] {
    CL_END, CL_SPACE, CL_ALPHA, CL_DIGIT, CL_PUNCT, CL_OTHER
  } char_class_e;

  scan_mode_e  mode_q;
  logic [31:0] offset_q;
  logic [31:0] start_q;
  logic [15:0] len_q;
  logic [47:0] window_q;   // last six identifier bytes, newest lowest
  token_t      token_q[$];  // predicted tokens not yet seen on the output
  int          fail_cnt;
  int          chk_cnt;

  function automatic char_class_e classify(input logic [7:0] b);
    if (b == CH_NUL) return CL_END;
    if (b == CH_SPACE || (b >= CH_TAB && b <= CH_CR)) return CL_SPACE;
    if (b == CH_UNDER || (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A))
      return CL_ALPHA;
    if (b >= 8'h30 && b <= 8'h39) return CL_DIGIT;
    case (b)
      CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE, CH_SEMI: return CL_PUNCT;
      default: return CL_OTHER;
    endcase
  endfunction

  function automatic logic [KIND_W-1:0] punct_of(input logic [7:0] b);
    case (b)
      CH_LPAREN: return KIND_LPAREN;
      CH_RPAREN: return KIND_RPAREN;
      CH_LBRACE: return KIND_LBRACE;
      CH_RBRACE: return KIND_RBRACE;
      default:   return KIND_SEMI;
    endcase
  endfunction

  // keyword only when the exact length matches; a saturated length never does
  function automatic logic [KIND_W-1:0] word_kind();
    if (len_q == 16'd3 && window_q[23:0] == KW_INT) return KIND_INT;
    if (len_q == 16'd4 && window_q[31:0] == KW_VOID) return KIND_VOID;
    if (len_q == 16'd6 && window_q == KW_RETURN) return KIND_RETURN;
    return KIND_IDENT;
  endfunction

  function automatic token_t mk(input logic [KIND_W-1:0] kind,
                                input logic [STAT_W-1:0] status,
                                input logic [31:0] start, input logic [15:0] length);
    token_t t;
    t.kind   = kind;
    t.status = status;
    t.start  = start;
    t.length = length;
    t.last   = 1'b0;
    return t;
  endfunction

  function automatic void scan_byte(input logic [7:0] b);
    token_t      found[$];
    logic [31:0] pos;
    char_class_e cls;
    bit          done;
    pos  = offset_q;
    cls  = classify(b);
    done = 1'b0;
    case (mode_q)
      MODE_DROP: begin
        // discarding until the zero byte, which itself gives nothing
        if (cls == CL_END) begin
          mode_q   = MODE_IDLE;
          offset_q = '0;
        end else begin
          offset_q = pos + 32'd1;
        end
        done = 1'b1;
      end
      MODE_IDENT: begin
        if (cls == CL_ALPHA || cls == CL_DIGIT) begin
          if (len_q != LEN_SAT) len_q = len_q + 16'd1;
          window_q = {window_q[39:0], b};
          offset_q = pos + 32'd1;
          done     = 1'b1;
        end else begin
          found.push_back(mk(word_kind(), ST_OK, start_q, len_q));
          mode_q = MODE_IDLE;
        end
      end
      MODE_CONST: begin
        if (cls == CL_DIGIT) begin
          if (len_q != LEN_SAT) len_q = len_q + 16'd1;
          offset_q = pos + 32'd1;
          done     = 1'b1;
        end else if (cls == CL_ALPHA) begin
          // constant is swallowed, only the error goes out
          found.push_back(mk(KIND_IDENT, ST_LETTER_AFTER_CONST, pos, 16'd0));
          mode_q   = MODE_DROP;
          offset_q = pos + 32'd1;
          done     = 1'b1;
        end else begin
          found.push_back(mk(KIND_CONST, ST_OK, start_q, len_q));
          mode_q = MODE_IDLE;
        end
      end
      default: ;
    endcase
    if (!done) begin
      case (cls)
        CL_END: begin
          found.push_back(mk(KIND_END, ST_OK, pos, 16'd0));
          offset_q = '0;
        end
        CL_SPACE: offset_q = pos + 32'd1;
        CL_ALPHA: begin
          mode_q   = MODE_IDENT;
          start_q  = pos;
          len_q    = 16'd1;
          window_q = {40'd0, b};
          offset_q = pos + 32'd1;
        end
        CL_DIGIT: begin
          mode_q   = MODE_CONST;
          start_q  = pos;
          len_q    = 16'd1;
          offset_q = pos + 32'd1;
        end
        CL_PUNCT: begin
          found.push_back(mk(punct_of(b), ST_OK, pos, 16'd1));
          offset_q = pos + 32'd1;
        end
        default: begin
          found.push_back(mk(KIND_IDENT, ST_UNEXPECTED, pos, 16'd0));
          mode_q   = MODE_DROP;
          offset_q = pos + 32'd1;
        end
      endcase
    end
    if (found.size() > 0) found[found.size()-1].last = 1'b1;
    foreach (found[i]) token_q.push_back(found[i]);
  endfunction

  function automatic void check_token();
    token_t got;
    token_t want;
    got.kind   = m_tuser_i[3:0];
    got.status = m_tuser_i[5:4];
    got.start  = m_tdata_i[31:0];
    got.length = m_tdata_i[47:32];
    got.last   = m_tlast_i;
    if (token_q.size() == 0) begin
      fail_cnt++;
      $display("%0t: token with nothing predicted: kind %0d status %0d start %0d len %0d last %0b",
               $time, got.kind, got.status, got.start, got.length, got.last);
    end else begin
      want = token_q.pop_front();
      chk_cnt++;
      if (got != want) begin
        fail_cnt++;
        $display("%0t: token mismatch: expected kind %0d status %0d start %0d len %0d last %0b",
                 $time, want.kind, want.status, want.start, want.length, want.last);
        $display("%0t:                 actual kind %0d status %0d start %0d len %0d last %0b",
                 $time, got.kind, got.status, got.start, got.length, got.last);
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   = MODE_IDLE;
      offset_q = '0;
      start_q  = '0;
      len_q    = '0;
      window_q = '0;
      token_q.delete();
      fail_cnt = 0;
      chk_cnt  = 0;
      failures_o    <= 0;
      outstanding_o <= 0;
      checked_o     <= 0;
    end else begin
      // a result never belongs to the byte accepted at the same edge
      if (m_tvalid_i && m_tready_i) check_token();
      if (s_tvalid_i && s_tready_i) scan_byte(s_tdata_i);
      failures_o    <= fail_cnt;
      outstanding_o <= token_q.size();
      checked_o     <= chk_cnt;
    end
  end

endmodule

// ===== tb/tb_c_subset_tokenizer.sv =====
`timescale 1ns / 1ps
// Testbench top for the C subset tokeniser: builds source byte streams, drives
// them with random idling and back-pressure, and gives the verdict from cst_token_checker.
module tb_c_subset_tokenizer;
  import cst_pkg::*;

  localparam int STALL_LIMIT = 2000;  // cycles with no request on either side
  localparam int QUIET_TAIL  = 150;   // final bytes sent with no idling
  localparam int LONG_WORD   = 40;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic [5:0]  m_tuser;
  logic        m_tlast;

  int failures;
  int outstanding;
  int checked;

  logic [7:0] src_q[$];  // source bytes waiting to be sent
  int gap_pct   = 0;     // chance of a sender gap before a byte
  int stall_pct = 0;     // chance of a receiver stall per cycle
  int sent_cnt  = 0;

  c_subset_tokenizer dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  cst_token_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_tvalid_i    (s_tvalid),
    .s_tready_i    (s_tready),
    .s_tdata_i     (s_tdata),
    .m_tvalid_i    (m_tvalid),
    .m_tready_i    (m_tready),
    .m_tdata_i     (m_tdata),
    .m_tuser_i     (m_tuser),
    .m_tlast_i     (m_tlast),
    .failures_o    (failures),
    .outstanding_o (outstanding),
    .checked_o     (checked)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // ---- source byte builders ----
  task automatic add_byte(input logic [7:0] b);
    src_q.push_back(b);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) src_q.push_back(s[i]);
  endtask

  function automatic logic [7:0] rand_alpha();
    int r;
    r = $urandom_range(0, 52);
    if (r < 26) return 8'(8'h61 + r);
    if (r < 52) return 8'(8'h41 + r - 26);
    return CH_UNDER;
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'(8'h30 + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_alnum();
    if ($urandom_range(0, 3) == 0) return rand_digit();
    return rand_alpha();
  endfunction

  // space or one of the control whitespace bytes 0x09..0x0D
  function automatic logic [7:0] rand_space();
    int r;
    r = $urandom_range(0, 5);
    if (r == 0) return CH_SPACE;
    return 8'(CH_TAB + r - 1);
  endfunction

  // mostly well-formed tokens, some end markers, errors and raw noise
  task automatic add_random_token();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 28) begin
      add_byte(rand_alpha());
      repeat ($urandom_range(0, 7)) add_byte(rand_alnum());
    end else if (sel < 43) begin
      case ($urandom_range(0, 2))
        0: add_text("int");
        1: add_text("void");
        default: add_text("return");
      endcase
    end else if (sel < 58) begin
      repeat ($urandom_range(1, 6)) add_byte(rand_digit());
    end else if (sel < 78) begin
      case ($urandom_range(0, 4))
        0: add_byte(CH_LPAREN);
        1: add_byte(CH_RPAREN);
        2: add_byte(CH_LBRACE);
        3: add_byte(CH_RBRACE);
        default: add_byte(CH_SEMI);
      endcase
    end else if (sel < 88) begin
      repeat ($urandom_range(1, 3)) add_byte(rand_space());
    end else if (sel < 93) begin
      add_byte(CH_NUL);
    end else if (sel < 96) begin
      // letter after constant, some discarded bytes, then a fresh source
      repeat ($urandom_range(1, 3)) add_byte(rand_digit());
      add_byte(rand_alpha());
      repeat ($urandom_range(0, 4)) add_byte(8'($urandom_range(1, 255)));
      add_byte(CH_NUL);
    end else begin
      add_byte(8'($urandom_range(0, 255)));
      repeat ($urandom_range(0, 3)) add_byte(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 1) == 1) add_byte(CH_NUL);
    end
    // words usually get a separator so keywords are seen as such
    if (sel < 58 && $urandom_range(0, 9) < 7) add_byte(rand_space());
  endtask

  // ---- driving ----
  task automatic send_src_byte(input logic [7:0] b);
    if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    sent_cnt++;
  endtask

  // idling rates change every 64 bytes; none once quiet_tail bytes remain
  task automatic stream_queue(input int quiet_tail);
    int n;
    n = 0;
    while (src_q.size() > 0) begin
      if (src_q.size() <= quiet_tail) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else if (n % 64 == 0) begin
        gap_pct   = $urandom_range(0, 3) * 15;
        stall_pct = $urandom_range(0, 3) * 15;
      end
      send_src_byte(src_q.pop_front());
      n++;
    end
    s_tvalid <= 1'b0;
  endtask

  // receiver back-pressure in bursts of random length
  initial begin
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(0, 12)) @(posedge clk_i);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // watchdog: ends the run when no request moves for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("Timeout: no request for %0d cycles, %0d tokens still due", STALL_LIMIT,
             outstanding);
    $display("Verification failed");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: every keyword and punctuator, tab, constant pending at end of
    // source, letter after constant with dropped bytes, and a high byte
    add_text("int void\treturn(){};9");
    add_byte(CH_NUL);
    add_text("7_");
    add_byte(8'h80);
    add_byte(CH_NUL);
    add_byte(8'hFF);
    add_byte(CH_NUL);
    stream_queue(0);

    // long identifier ending in a keyword spelling, so it stays an identifier
    repeat (LONG_WORD) add_byte(8'h61);
    add_text("return");
    add_byte(CH_SPACE);
    add_byte(CH_NUL);
    stream_queue(1 << 30);

    // random sources
    while (src_q.size() < 1000) add_random_token();
    add_byte(CH_NUL);
    stream_queue(QUIET_TAIL);

    // drain; the watchdog covers a block that never delivers
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);

    $display("Sent %0d source bytes: directed cases, a %0d-byte identifier and random sources.",
             sent_cnt, LONG_WORD + 6);
    $display("Checked %0d tokens, end markers and error results; %0d failures.",
             checked, failures);
    if (failures == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
